// ----- src/rfs_pkg.sv -----
// Shared types and constants for the radar frame sync and point extractor.
// No dependencies; used by rfs_core and the top level.
`timescale 1ns / 1ps

package rfs_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;

    localparam logic [63:0] MAGIC_WORD   = 64'h0201_0403_0605_0807;
    localparam logic [31:0] HEAD_LEN     = 32'd40;
    localparam logic [15:0] MAX_LEN_RST  = 16'd4096;
    localparam logic [31:0] PT_TYPE_RST  = 32'd1;

    // Configuration register indexes.
    localparam logic REG_MAX_FRAME_LEN  = 1'b0;
    localparam logic REG_POINT_TLV_TYPE = 1'b1;

    // Result kinds.
    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [31:0] speed_bits;
        logic [31:0] object_count;
        logic [31:0] tlv_count;
        logic [6:0]  point_count;
        logic        last;
    } res_t;

    // Results produced by one accepted byte: a point, a summary, or both.
    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } core_out_t;

endpackage

// ----- src/rfs_core.sv -----
// Frame sync, header capture and TLV walk; one byte per cycle while take is high.
// Depends on rfs_pkg. Holds the configuration registers and all parser state.
`timescale 1ns / 1ps

module rfs_core
    import rfs_pkg::*;
#(
    parameter int unsigned MAX_POINTS_PER_FRAME = MAX_POINTS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_addr,
    input  logic [31:0]     cfg_wdata,
    input  logic            take,
    input  logic [7:0]      data_byte,
    output core_out_t       co
);

    localparam int unsigned PE_W = $clog2(MAX_POINTS_PER_FRAME + 1);

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_HDR  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    logic [15:0] max_len_reg;
    logic [31:0] pt_type_reg;

    phase_t      phase_reg, phase_next;
    logic [63:0] window_reg, window_next;
    logic [4:0]  hbs_reg, hbs_next;
    logic [31:0] hdr_len_reg, hdr_len_next;
    logic [31:0] obj_reg, obj_next;
    logic [31:0] tlvc_reg, tlvc_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] pbs_reg, pbs_next;
    logic [31:0] started_reg, started_next;
    logic [63:0] head_reg, head_next;
    logic [2:0]  hc_reg, hc_next;
    logic [31:0] left_reg, left_next;
    logic        in_pt_reg, in_pt_next;
    logic [31:0] pw_reg [4];
    logic [31:0] pw_next [4];
    logic [3:0]  pbi_reg, pbi_next;
    logic [PE_W-1:0] pe_reg, pe_next;
    logic        stop_reg, stop_next;

    function automatic res_t mk_summary(logic [31:0] objs, logic [31:0] tlvs,
                                        logic [PE_W-1:0] npts);
        res_t        r;
        logic [31:0] n32;
        n32 = 32'(npts);
        r = '0;
        r.kind         = KIND_SUMMARY;
        r.object_count = objs;
        r.tlv_count    = tlvs;
        r.point_count  = n32[6:0];
        return r;
    endfunction

    always_comb
    begin
        logic [31:0] total;
        logic [15:0] need;
        logic [15:0] pbs_new;
        logic [31:0] remaining;
        logic        emit_pt;
        logic        emit_sum;
        res_t        pt_res;
        res_t        sum_res;

        phase_next     = phase_reg;
        window_next    = window_reg;
        hbs_next       = hbs_reg;
        hdr_len_next   = hdr_len_reg;
        obj_next       = obj_reg;
        tlvc_next      = tlvc_reg;
        frame_len_next = frame_len_reg;
        pbs_next       = pbs_reg;
        started_next   = started_reg;
        head_next      = head_reg;
        hc_next        = hc_reg;
        left_next      = left_reg;
        in_pt_next     = in_pt_reg;
        pw_next        = pw_reg;
        pbi_next       = pbi_reg;
        pe_next        = pe_reg;
        stop_next      = stop_reg;
        total     = '0;
        need      = '0;
        pbs_new   = '0;
        remaining = '0;
        emit_pt   = 1'b0;
        emit_sum  = 1'b0;
        pt_res    = '0;
        sum_res   = '0;
        co        = '0;

        unique case (phase_reg)
            PH_HDR:
            begin
                unique case (hbs_reg[4:2])
                    3'd1:    hdr_len_next[{hbs_reg[1:0], 3'b000} +: 8] = data_byte;
                    3'd5:    obj_next[{hbs_reg[1:0], 3'b000} +: 8]     = data_byte;
                    3'd6:    tlvc_next[{hbs_reg[1:0], 3'b000} +: 8]    = data_byte;
                    default: ;
                endcase
                hbs_next = hbs_reg + 5'd1;
                if (hbs_reg == 5'd31)
                begin
                    total = hdr_len_reg;
                    if (total < HEAD_LEN || total > {16'd0, max_len_reg})
                    begin
                        phase_next = PH_SYNC;
                    end
                    else
                    begin
                        frame_len_next = total[15:0];
                        pbs_next     = '0;
                        started_next = '0;
                        head_next    = '0;
                        hc_next      = '0;
                        left_next    = '0;
                        in_pt_next   = 1'b0;
                        pbi_next     = '0;
                        pe_next      = '0;
                        stop_next    = 1'b0;
                        if (total == HEAD_LEN)
                        begin
                            emit_sum   = 1'b1;
                            phase_next = PH_SYNC;
                        end
                        else
                        begin
                            phase_next = PH_PAY;
                        end
                    end
                end
            end
            PH_PAY:
            begin
                need      = frame_len_reg - HEAD_LEN[15:0];
                pbs_new   = pbs_reg + 16'd1;
                pbs_next  = pbs_new;
                remaining = (need >= pbs_new) ? 32'(need - pbs_new) : 32'd0;
                if (!stop_reg)
                begin
                    if (left_reg != 32'd0)
                    begin
                        left_next = left_reg - 32'd1;
                        if (in_pt_reg)
                        begin
                            pw_next[pbi_reg[3:2]][{pbi_reg[1:0], 3'b000} +: 8] = data_byte;
                            pbi_next = pbi_reg + 4'd1;
                            if (pbi_reg == 4'd15 &&
                                pe_reg < PE_W'(MAX_POINTS_PER_FRAME))
                            begin
                                emit_pt = 1'b1;
                                pe_next = pe_reg + PE_W'(1);
                            end
                        end
                        if (left_reg == 32'd1)
                        begin
                            in_pt_next = 1'b0;
                            pbi_next   = '0;
                        end
                    end
                    else if (hc_reg == 3'd0 && started_reg >= tlvc_reg)
                    begin
                        // Declared TLV count reached: the rest is only counted.
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        if (hc_reg == 3'd0)
                        begin
                            started_next = started_reg + 32'd1;
                            head_next    = '0;
                        end
                        head_next[{hc_reg, 3'b000} +: 8] = data_byte;
                        hc_next = hc_reg + 3'd1;
                        if (hc_reg == 3'd7)
                        begin
                            if (head_next[63:32] > remaining)
                            begin
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                left_next  = head_next[63:32];
                                in_pt_next = (head_next[31:0] == pt_type_reg) &&
                                             (head_next[63:32] != 32'd0);
                                pbi_next   = '0;
                            end
                        end
                    end
                end
                if (pbs_new >= need)
                begin
                    emit_sum   = 1'b1;
                    phase_next = PH_SYNC;
                end
            end
            default:
            begin
                phase_next  = PH_SYNC;
                window_next = {window_reg[55:0], data_byte};
                if (window_next == MAGIC_WORD)
                begin
                    hbs_next   = '0;
                    phase_next = PH_HDR;
                end
            end
        endcase

        pt_res            = '0;
        pt_res.kind       = KIND_POINT;
        pt_res.x_bits     = pw_next[0];
        pt_res.y_bits     = pw_next[1];
        pt_res.z_bits     = pw_next[2];
        pt_res.speed_bits = pw_next[3];
        sum_res = mk_summary(obj_next, tlvc_next, pe_next);

        if (emit_pt)
        begin
            co.r0 = pt_res;
            if (emit_sum)
            begin
                co.r1      = sum_res;
                co.r1.last = 1'b1;
                co.num     = 2'd2;
            end
            else
            begin
                co.r0.last = 1'b1;
                co.num     = 2'd1;
            end
        end
        else if (emit_sum)
        begin
            co.r0      = sum_res;
            co.r0.last = 1'b1;
            co.num     = 2'd1;
        end

        if (!take)
        begin
            co.num = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RST;
            pt_type_reg   <= PT_TYPE_RST;
            phase_reg     <= PH_SYNC;
            window_reg    <= '0;
            hbs_reg       <= '0;
            frame_len_reg <= '0;
            pbs_reg       <= '0;
            started_reg   <= '0;
            head_reg      <= '0;
            hc_reg        <= '0;
            left_reg      <= '0;
            in_pt_reg     <= 1'b0;
            pbi_reg       <= '0;
            pe_reg        <= '0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MAX_FRAME_LEN:  max_len_reg <= cfg_wdata[15:0];
                    REG_POINT_TLV_TYPE: pt_type_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (take)
            begin
                phase_reg     <= phase_next;
                window_reg    <= window_next;
                hbs_reg       <= hbs_next;
                frame_len_reg <= frame_len_next;
                pbs_reg       <= pbs_next;
                started_reg   <= started_next;
                head_reg      <= head_next;
                hc_reg        <= hc_next;
                left_reg      <= left_next;
                in_pt_reg     <= in_pt_next;
                pbi_reg       <= pbi_next;
                pe_reg        <= pe_next;
                stop_reg      <= stop_next;
            end
        end
    end

    // Header words and point words are payload: always written before read.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hdr_len_reg <= hdr_len_next;
            obj_reg     <= obj_next;
            tlvc_reg    <= tlvc_next;
            pw_reg      <= pw_next;
        end
    end

endmodule

// ----- src/radar_frame_sync_tlv_point_extractor.sv -----
// Top level: byte stream in, point and frame summary beats out.
// Depends on rfs_pkg and rfs_core; holds the three-entry result queue.
//
//   channel   direction  beat contents
//   s_*       in         tdata[7:0] data_byte
//   m_*       out        tdata: x, y, z, speed, object_count, tlv_count, point_count
//                        tuser: kind; tlast: last
//   cfg_*     in         write enable, register index, 32-bit write data
//
// Each accepted byte is parsed in the cycle it is accepted; its results enter
// the queue at that edge and appear on m_* the next cycle if no earlier beat waits.
// With m_tready high, one byte per cycle is sustained while each byte yields at
// most one result; a frame's last payload byte may yield two, drained one per cycle.
// s_tready is high while the queue holds at most one beat, so output stalls
// back up to the input after two beats. Reset returns the parser to syncing.
`timescale 1ns / 1ps

module radar_frame_sync_tlv_point_extractor
    import rfs_pkg::*;
#(
    parameter int unsigned MAX_POINTS_PER_FRAME = MAX_POINTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] x_bits, [63:32] y_bits, [95:64] z_bits, [127:96] speed_bits,
    // [159:128] object_count, [191:160] tlv_count, [198:192] point_count,
    // [199] zero
    output logic [199:0] m_tdata,
    output logic [0:0]   m_tuser,     // [0] kind
    output logic         m_tlast
);

    core_out_t  co;
    logic       take;
    logic       pop;
    logic [1:0] base;
    logic [1:0] cnt_reg, cnt_next;
    res_t       q_reg [3];
    res_t       q_next [3];

    assign take = s_tvalid && s_tready;

    rfs_core #(
        .MAX_POINTS_PER_FRAME(MAX_POINTS_PER_FRAME)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .data_byte (s_tdata),
        .co        (co)
    );

    assign s_tready = (cnt_reg <= 2'd1);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign base     = cnt_reg - {1'b0, pop};

    always_comb
    begin
        q_next = q_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (co.num != 2'd0 && 2'(i) == base)
            begin
                q_next[i] = co.r0;
            end
            if (co.num == 2'd2 && 2'(i) == base + 2'd1)
            begin
                q_next[i] = co.r1;
            end
        end
        cnt_next = base + co.num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign m_tdata = {1'b0, q_reg[0].point_count, q_reg[0].tlv_count,
                      q_reg[0].object_count, q_reg[0].speed_bits, q_reg[0].z_bits,
                      q_reg[0].y_bits, q_reg[0].x_bits};
    assign m_tuser = q_reg[0].kind;
    assign m_tlast = q_reg[0].last;

endmodule
